/* rtl/otb_pkg.sv */
// ----------------------------------------------------------------------------
// otb_pkg
// Types, constants and command/status bundles shared by the order book files.
// ----------------------------------------------------------------------------
`default_nettype none

package otb_pkg;

	localparam int ORDER_SLOTS = 64;
	localparam int PRICE_BITS  = 20;
	localparam int QTY_BITS    = 24;
	localparam int SLOT_BITS   = $clog2(ORDER_SLOTS);
	localparam int ARR_BITS    = 32;
	localparam int ID_BITS     = 16;

	localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(ORDER_SLOTS - 1);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_MATCH  = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	typedef enum logic {
		SIDE_BUY  = 1'b0,
		SIDE_SELL = 1'b1
	} side_t;

	typedef enum logic [2:0] {
		ST_RESTED   = 3'd0,
		ST_FILLED   = 3'd1,
		ST_REJECT   = 3'd2,
		ST_CANCEL   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_EVAL,
		S_FILL,
		S_FREE,
		S_REST,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [ID_BITS-1:0]    owner_id;
		logic [QTY_BITS-1:0]   quantity;
		logic [ARR_BITS-1:0]   arrival;
	} entry_t;

	typedef struct packed {
		logic    in_ready;
		logic    scan_start;
		logic    scan_run;
		logic    fill;
		logic    free_start;
		logic    free_step;
		logic    rest;
		logic    set_status;
		status_t status;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] kind;
		logic       qty_zero;
		logic       price_zero;
		logic       scan_done;
		logic       best_found;
		logic       any_cancel;
		logic       fill_done;
		logic       free_hit;
		logic       free_last;
		logic       out_busy;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/otb_if.sv */
// ----------------------------------------------------------------------------
// otb_item_if / otb_res_if
// Valid/ready channels for incoming order words and outgoing status words.
// ----------------------------------------------------------------------------
`default_nettype none

interface otb_item_if;
	import otb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [ID_BITS-1:0]    ord_ref;
	logic                  side;
	logic [PRICE_BITS-1:0] price;
	logic [QTY_BITS-1:0]   quantity;

	modport source (output valid, kind, ord_ref, side, price, quantity, input ready);
	modport sink (input valid, kind, ord_ref, side, price, quantity, output ready);
endinterface

interface otb_res_if;
	import otb_pkg::*;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic [QTY_BITS-1:0] filled_quantity;
	logic [QTY_BITS-1:0] rested_quantity;

	modport source (output valid, status, filled_quantity, rested_quantity, input ready);
	modport sink (input valid, status, filled_quantity, rested_quantity, output ready);
endinterface

`default_nettype wire

/* rtl/price_time_order_book_top.sv */
// ----------------------------------------------------------------------------
// price_time_order_book_top
// Price-time priority limit order book over a 64-slot resting order store.
// ----------------------------------------------------------------------------
// Usage. Order words enter on the item channel (add, match or cancel) and
// each produces exactly one status word on the result channel, carrying the
// status code, the quantity filled and the quantity left resting.
// One word is worked on at a time. A scan reads the slot store from its
// single read port, one slot per cycle, and holds the sequencer until the
// last slot has been read. A cancel runs decode, scan, evaluate and respond.
// A match runs decode, then a scan, an evaluation and a fill for each
// crossing order; a remainder adds a final scan and evaluation, then, for a
// nonzero price, a search of the valid bits for a free slot. An add is
// decided by the free-slot search, which tests one valid bit a cycle. The
// next word is taken in the cycle after the status word is loaded.
// Reset empties the store and clears the arrival counter at once; no
// clearing pass is needed as every slot has its own valid flip-flop.
// The status word sits in an output register, so a stalled receiver only
// holds the next result, and with it the input, once that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module price_time_order_book_top (
	input  logic      clk,
	input  logic      arst_n,
	otb_item_if.sink  item,
	otb_res_if.source result
);
	import otb_pkg::*;

	// Commands from the sequencer and status flags back from the datapath.
	cmd_t cmd;
	sts_t sts;

	otb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	otb_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire

/* rtl/otb_ctrl.sv */
// ----------------------------------------------------------------------------
// otb_ctrl
// Sequencer that steps the datapath through decode, scans, fills and resting.
// ----------------------------------------------------------------------------
`default_nettype none

module otb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  otb_pkg::sts_t sts,
	output otb_pkg::cmd_t cmd
);
	import otb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_REJECT;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.kind)
					KIND_ADD: begin
						if (sts.qty_zero || sts.price_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_REJECT;
							state_d        = S_RESP;
						end else begin
							cmd.free_start = 1'b1;
							state_d        = S_FREE;
						end
					end
					KIND_MATCH: begin
						if (sts.qty_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_REJECT;
							state_d        = S_RESP;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					KIND_CANCEL: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_REJECT;
						state_d        = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.kind == KIND_CANCEL) begin
					cmd.set_status = 1'b1;
					cmd.status     = sts.any_cancel ? ST_CANCEL : ST_NOTFOUND;
					state_d        = S_RESP;
				end else if (sts.best_found) begin
					state_d = S_FILL;
				end else if (sts.price_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_REJECT;
					state_d        = S_RESP;
				end else begin
					cmd.free_start = 1'b1;
					state_d        = S_FREE;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FILLED;
					state_d        = S_RESP;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_FREE: begin
				if (sts.free_hit) begin
					state_d = S_REST;
				end else if (sts.free_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_FULL;
					state_d        = S_RESP;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			S_REST: begin
				cmd.rest       = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = ST_RESTED;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/otb_dpath.sv */
// ----------------------------------------------------------------------------
// otb_dpath
// Slot store, scan pipeline, best-order tracking, fill arithmetic and output.
// ----------------------------------------------------------------------------
`default_nettype none

module otb_dpath (
	input  logic          clk,
	input  logic          arst_n,
	otb_item_if.sink      item,
	otb_res_if.source     result,
	input  otb_pkg::cmd_t cmd,
	output otb_pkg::sts_t sts
);
	import otb_pkg::*;

	entry_t mem [ORDER_SLOTS];

	logic [ORDER_SLOTS-1:0] valid_q;
	logic [1:0]             kind_q;
	logic [ID_BITS-1:0]     id_q;
	logic                   side_q;
	logic [PRICE_BITS-1:0]  price_q;
	logic [QTY_BITS-1:0]    qty_q;
	logic [QTY_BITS-1:0]    left_q;
	logic [QTY_BITS-1:0]    rested_q;
	status_t                status_q;
	logic [SLOT_BITS-1:0]   scan_addr_q;
	logic                   issue_done_q;
	logic                   vld_s1;
	logic                   slot_vld_s1;
	logic [SLOT_BITS-1:0]   idx_s1;
	entry_t                 ent_s1;
	logic                   best_found_q;
	logic [SLOT_BITS-1:0]   best_idx_q;
	entry_t                 best_ent_q;
	logic [ARR_BITS-1:0]    best_age_q;
	logic                   any_q;
	logic [SLOT_BITS-1:0]   free_idx_q;
	logic [ARR_BITS-1:0]    arrival_q;
	logic                   out_vld_q;
	logic [2:0]             out_status_q;
	logic [QTY_BITS-1:0]    out_filled_q;
	logic [QTY_BITS-1:0]    out_rested_q;

	logic                   load_item;
	logic                   issue;
	logic [ARR_BITS-1:0]    age_s1;
	logic                   crosses;
	logic                   cand;
	logic                   better;
	logic                   hit_cancel;
	logic                   wr_en;
	logic [SLOT_BITS-1:0]   wr_addr;
	entry_t                 wr_data;
	logic                   partial_fill;

	assign load_item    = item.valid && cmd.in_ready;
	assign issue        = cmd.scan_run && !issue_done_q;
	assign age_s1       = arrival_q - ent_s1.arrival;
	assign crosses      = (side_q == SIDE_BUY) ? (ent_s1.price <= price_q)
	                                           : (ent_s1.price >= price_q);
	assign cand         = vld_s1 && slot_vld_s1 && (kind_q == KIND_MATCH)
	                      && (ent_s1.side != side_q) && crosses;
	assign hit_cancel   = vld_s1 && slot_vld_s1 && (kind_q == KIND_CANCEL)
	                      && (ent_s1.owner_id == id_q);
	assign partial_fill = best_ent_q.quantity > left_q;

	always_comb begin
		if (!best_found_q) begin
			better = 1'b1;
		end else if (ent_s1.price != best_ent_q.price) begin
			better = (side_q == SIDE_BUY) ? (ent_s1.price < best_ent_q.price)
			                              : (ent_s1.price > best_ent_q.price);
		end else begin
			better = age_s1 > best_age_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = best_ent_q;
		if (cmd.fill) begin
			wr_en            = partial_fill;
			wr_data.quantity = best_ent_q.quantity - left_q;
		end else if (cmd.rest) begin
			wr_en   = 1'b1;
			wr_addr = free_idx_q;
			wr_data = '{side: side_q, price: price_q, owner_id: id_q,
			            quantity: left_q, arrival: arrival_q};
		end
	end

	// Slot store: one write port, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		ent_s1 <= mem[scan_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			best_found_q <= 1'b0;
			any_q        <= 1'b0;
			arrival_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.scan_start) begin
				issue_done_q <= 1'b0;
				best_found_q <= 1'b0;
				any_q        <= 1'b0;
			end else begin
				if (issue && scan_addr_q == SLOT_LAST) begin
					issue_done_q <= 1'b1;
				end
				if (cand && better) begin
					best_found_q <= 1'b1;
				end
				if (hit_cancel) begin
					any_q <= 1'b1;
				end
			end
			if (hit_cancel) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.fill && !partial_fill) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (cmd.rest) begin
				valid_q[free_idx_q] <= 1'b1;
				arrival_q           <= arrival_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			kind_q   <= item.kind;
			id_q     <= item.ord_ref;
			side_q   <= item.side;
			price_q  <= item.price;
			qty_q    <= item.quantity;
			left_q   <= item.quantity;
			rested_q <= '0;
		end
		if (cmd.scan_start) begin
			scan_addr_q <= '0;
		end else if (issue) begin
			scan_addr_q <= scan_addr_q + 1'b1;
		end
		slot_vld_s1 <= valid_q[scan_addr_q];
		idx_s1      <= scan_addr_q;
		if (cand && better) begin
			best_idx_q <= idx_s1;
			best_ent_q <= ent_s1;
			best_age_q <= age_s1;
		end
		if (cmd.fill) begin
			left_q <= partial_fill ? '0 : left_q - best_ent_q.quantity;
		end
		if (cmd.rest) begin
			rested_q <= left_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.free_start) begin
			free_idx_q <= '0;
		end else if (cmd.free_step) begin
			free_idx_q <= free_idx_q + 1'b1;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_filled_q <= qty_q - left_q;
			out_rested_q <= rested_q;
		end
	end

	assign item.ready             = cmd.in_ready;
	assign result.valid           = out_vld_q;
	assign result.status          = out_status_q;
	assign result.filled_quantity = out_filled_q;
	assign result.rested_quantity = out_rested_q;

	assign sts.in_valid   = item.valid;
	assign sts.kind       = kind_q;
	assign sts.qty_zero   = (qty_q == '0);
	assign sts.price_zero = (price_q == '0);
	assign sts.scan_done  = vld_s1 && (idx_s1 == SLOT_LAST);
	assign sts.best_found = best_found_q;
	assign sts.any_cancel = any_q;
	assign sts.fill_done  = !(left_q > best_ent_q.quantity);
	assign sts.free_hit   = !valid_q[free_idx_q];
	assign sts.free_last  = (free_idx_q == SLOT_LAST);
	assign sts.out_busy   = out_vld_q && !result.ready;

	a_fill_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> best_found_q)
		else $error("fill applied with no crossing order found");

	a_rest_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest |-> !valid_q[free_idx_q])
		else $error("order rested into an occupied slot");

	a_cancel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cancel |=> !valid_q[$past(idx_s1)])
		else $error("cancelled slot still valid");

	a_arrival_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest |=> arrival_q == $past(arrival_q) + 1'b1)
		else $error("arrival counter not advanced on rest");

endmodule

`default_nettype wire

/* test/price_time_order_book_top_tb.sv */
// ----------------------------------------------------------------------------
// price_time_order_book_top_tb
// Self-checking bench for the price-time priority order book.
// ----------------------------------------------------------------------------
// A short table of directed words covers rejections, the price and quantity
// extremes, both sides, cancels and the undefined kind. Random trading follows,
// with floods that fill the store and sweeps that empty it. Every accepted
// word is run through a behavioural book kept in the bench, and each status
// word that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module price_time_order_book_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import otb_pkg::*;

	typedef struct {
		logic [1:0]            kind;
		logic [ID_BITS-1:0]    id;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} order_word_t;

	typedef struct {
		logic [2:0]          status;
		logic [QTY_BITS-1:0] filled;
		logic [QTY_BITS-1:0] rested;
	} status_word_t;

	// A directed row; the expected status word is only given where known.
	typedef struct {
		order_word_t  w;
		bit           typed;
		status_word_t exp;
	} dir_row_t;

	localparam logic [PRICE_BITS-1:0] P_MAX = '1;
	localparam logic [QTY_BITS-1:0]   Q_MAX = '1;
	localparam logic [1:0]            KIND_NONE = 2'd3;
	localparam int                    RANDOM_WORDS = 1550;

	logic clk;
	logic arst_n;

	otb_item_if item ();
	otb_res_if  result ();

	price_time_order_book_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	// Shadow copy of the book.
	logic                  book_valid [ORDER_SLOTS];
	logic                  book_side  [ORDER_SLOTS];
	logic [PRICE_BITS-1:0] book_price [ORDER_SLOTS];
	logic [ID_BITS-1:0]    book_id    [ORDER_SLOTS];
	logic [QTY_BITS-1:0]   book_qty   [ORDER_SLOTS];
	logic [31:0]           book_arr   [ORDER_SLOTS];
	logic [31:0]           arrival_seq;

	status_word_t pending_status[$];
	int           err_cnt;
	bit           quiet;
	int           stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#600ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_bad(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic int free_slot();
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			if (!book_valid[i])
				return i;
		end
		return -1;
	endfunction

	// Rests an order in the lowest free slot and returns the status.
	function automatic logic [2:0] place_order(input order_word_t w,
			input logic [QTY_BITS-1:0] q);
		int s;
		if (q == '0 || w.price == '0)
			return ST_REJECT;
		s = free_slot();
		if (s < 0)
			return ST_FULL;
		book_valid[s] = 1'b1;
		book_side[s]  = w.side;
		book_price[s] = w.price;
		book_id[s]    = w.id;
		book_qty[s]   = q;
		book_arr[s]   = arrival_seq;
		arrival_seq++;
		return ST_RESTED;
	endfunction

	// Best crossing opposite order: best price, then oldest, then lowest slot.
	function automatic int best_cross(input logic side, input logic [PRICE_BITS-1:0] px);
		int best;
		logic [31:0] age_i, age_b;
		best = -1;
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			if (!book_valid[i] || book_side[i] == side)
				continue;
			if (side == SIDE_BUY ? (book_price[i] > px) : (book_price[i] < px))
				continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			age_i = arrival_seq - book_arr[i];
			age_b = arrival_seq - book_arr[best];
			if (book_price[i] != book_price[best]) begin
				if (side == SIDE_BUY ? (book_price[i] < book_price[best])
						: (book_price[i] > book_price[best]))
					best = i;
			end else if (age_i > age_b) begin
				best = i;
			end
		end
		return best;
	endfunction

	// Applies one word to the shadow book and returns its status word.
	function automatic status_word_t book_apply(input order_word_t w);
		status_word_t r;
		logic [QTY_BITS-1:0] left;
		int b;
		bit any;
		r = '{ST_REJECT, '0, '0};
		if (w.kind == KIND_ADD) begin
			r.status = place_order(w, w.qty);
			if (r.status == ST_RESTED)
				r.rested = w.qty;
		end else if (w.kind == KIND_MATCH) begin
			if (w.qty != '0) begin
				left = w.qty;
				while (left != '0) begin
					b = best_cross(w.side, w.price);
					if (b < 0)
						break;
					if (book_qty[b] > left) begin
						book_qty[b] -= left;
						left = '0;
					end else begin
						left -= book_qty[b];
						book_valid[b] = 1'b0;
					end
				end
				r.filled = w.qty - left;
				if (left == '0) begin
					r.status = ST_FILLED;
				end else begin
					r.status = place_order(w, left);
					if (r.status == ST_RESTED)
						r.rested = left;
				end
			end
		end else if (w.kind == KIND_CANCEL) begin
			any = 0;
			for (int i = 0; i < ORDER_SLOTS; i++) begin
				if (book_valid[i] && book_id[i] == w.id) begin
					book_valid[i] = 1'b0;
					any = 1;
				end
			end
			r.status = any ? ST_CANCEL : ST_NOTFOUND;
		end
		return r;
	endfunction

	// Presents one word, with an optional idle burst first, and waits for it
	// to be taken. The prediction is queued at the accepting edge.
	task automatic send_word(input order_word_t w, input bit typed, input status_word_t exp);
		status_word_t p;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item.valid    <= 1'b1;
		item.kind     <= w.kind;
		item.ord_ref  <= w.id;
		item.side     <= w.side;
		item.price    <= w.price;
		item.quantity <= w.qty;
		do
			@(posedge clk);
		while (!item.ready);
		p = book_apply(w);
		pending_status = {pending_status, (typed ? exp : p)};
	endtask

	function automatic logic [ID_BITS-1:0] pick_id();
		return ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(0, 31));
	endfunction

	function automatic logic [PRICE_BITS-1:0] pick_price();
		case ($urandom_range(0, 9))
			0: return PRICE_BITS'($urandom);
			1: return $urandom_range(0, 1) ? P_MAX : '0;
			default: return PRICE_BITS'(1000 + $urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [QTY_BITS-1:0] pick_qty();
		case ($urandom_range(0, 19))
			0: return QTY_BITS'($urandom);
			1: return $urandom_range(0, 1) ? Q_MAX : '0;
			default: return QTY_BITS'($urandom_range(1, 200));
		endcase
	endfunction

	function automatic order_word_t mixed_word();
		order_word_t w;
		int k;
		k = $urandom_range(0, 99);
		w.kind  = (k < 30) ? KIND_ADD : (k < 72) ? KIND_MATCH : (k < 97) ? KIND_CANCEL : KIND_NONE;
		w.id    = pick_id();
		w.side  = 1'($urandom_range(0, 1));
		w.price = pick_price();
		w.qty   = pick_qty();
		return w;
	endfunction

	// Result side: random ready stalls, checking at each handshake.
	always @(posedge clk or negedge arst_n) begin
		status_word_t e;
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_status.size() == 0) begin
					report_bad("status word with nothing expected");
				end else begin
					e = pending_status.pop_front();
					if (result.status !== e.status)
						report_bad($sformatf("status %0d, expected %0d", result.status, e.status));
					if (result.filled_quantity !== e.filled)
						report_bad($sformatf("filled %0d, expected %0d",
							result.filled_quantity, e.filled));
					if (result.rested_quantity !== e.rested)
						report_bad($sformatf("rested %0d, expected %0d",
							result.rested_quantity, e.rested));
				end
			end
			if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				result.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left   <= $urandom_range(0, 11);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		order_word_t w;
		status_word_t none;
		int sent;
		int ph;

		none        = '{ST_REJECT, '0, '0};
		err_cnt     = 0;
		quiet       = 0;
		arrival_seq = '0;
		foreach (book_valid[i])
			book_valid[i] = 1'b0;

		item.valid    = 1'b0;
		item.kind     = KIND_ADD;
		item.ord_ref  = '0;
		item.side     = SIDE_BUY;
		item.price    = '0;
		item.quantity = '0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejections, the undefined kind, extremes of both sides, price-zero
		// matches on either side, partial fills and cancels.
		rows = '{
			'{'{KIND_ADD, 16'd7, SIDE_BUY, 20'd100, '0}, 1, '{ST_REJECT, '0, '0}},
			'{'{KIND_ADD, 16'd7, SIDE_SELL, '0, 24'd10}, 1, '{ST_REJECT, '0, '0}},
			'{'{KIND_MATCH, 16'd7, SIDE_BUY, P_MAX, '0}, 1, '{ST_REJECT, '0, '0}},
			'{'{KIND_NONE, '1, SIDE_SELL, P_MAX, Q_MAX}, 1, '{ST_REJECT, '0, '0}},
			'{'{KIND_CANCEL, '1, SIDE_BUY, '0, '0}, 1, '{ST_NOTFOUND, '0, '0}},
			'{'{KIND_ADD, 16'd1, SIDE_BUY, P_MAX, Q_MAX}, 1, '{ST_RESTED, '0, Q_MAX}},
			'{'{KIND_ADD, 16'd2, SIDE_SELL, 20'd1, 24'd1}, 1, '{ST_RESTED, '0, 24'd1}},
			'{'{KIND_MATCH, 16'd3, SIDE_SELL, '0, 24'd5}, 1, '{ST_FILLED, 24'd5, '0}},
			'{'{KIND_MATCH, 16'd3, SIDE_BUY, '0, 24'd3}, 1, '{ST_REJECT, '0, '0}},
			'{'{KIND_MATCH, 16'd4, SIDE_BUY, 20'd1, 24'd4}, 0, none},
			'{'{KIND_ADD, 16'd5, SIDE_SELL, 20'd50, 24'd20}, 0, none},
			'{'{KIND_ADD, 16'd6, SIDE_SELL, 20'd50, 24'd20}, 0, none},
			'{'{KIND_ADD, 16'd5, SIDE_SELL, 20'd40, 24'd7}, 0, none},
			'{'{KIND_MATCH, 16'd8, SIDE_BUY, 20'd50, 24'd30}, 0, none},
			'{'{KIND_MATCH, 16'd9, SIDE_SELL, '0, Q_MAX}, 0, none},
			'{'{KIND_CANCEL, 16'd5, SIDE_SELL, '0, '0}, 0, none},
			'{'{KIND_CANCEL, 16'd4, SIDE_BUY, '0, '0}, 0, none},
			'{'{KIND_MATCH, 16'hFFFF, SIDE_BUY, P_MAX, Q_MAX}, 0, none},
			'{'{KIND_CANCEL, 16'hFFFF, SIDE_SELL, '0, '0}, 0, none}
		};
		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].exp);

		// Hold off until every directed word has been answered.
		item.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		@(posedge clk);

		// Random part, in phases: ordinary trading, floods that fill the
		// store so remainders meet a full book, and sweeps that clear it.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent > RANDOM_WORDS - 150)
				quiet = 1;
			ph = $urandom_range(0, 5);
			if (ph == 0) begin
				repeat (70) begin
					w = mixed_word();
					w.kind = KIND_ADD;
					send_word(w, 0, none);
					sent++;
				end
				repeat (6) begin
					w = mixed_word();
					w.kind = KIND_MATCH;
					send_word(w, 0, none);
					sent++;
				end
				w = '{KIND_MATCH, pick_id(), SIDE_SELL, '0, Q_MAX};
				send_word(w, 0, none);
				w = '{KIND_MATCH, pick_id(), SIDE_BUY, P_MAX, Q_MAX};
				send_word(w, 0, none);
				sent += 2;
			end else begin
				repeat (40) begin
					send_word(mixed_word(), 0, none);
					sent++;
				end
			end
			// Let the block drain completely now and then, early on.
			if (ph == 1 && sent < 600) begin
				item.valid <= 1'b0;
				wait (pending_status.size() == 0);
				@(posedge clk);
			end
		end
		item.valid <= 1'b0;

		wait (pending_status.size() == 0);
		repeat (200) @(posedge clk);
		if (err_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
